// ===== rtl/shtp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shtp_pkg
// shared constants, types and the mix word rom for the string hash table probe
// ----------------------------------------------------------------------------
package shtp_pkg;

    localparam int unsigned TABLE_DEPTH_DEF = 1024;
    localparam int unsigned LEN_W           = 11;
    localparam int unsigned SLOT_OUT_W      = 10;
    localparam int unsigned MIX_DEPTH       = 768;
    localparam logic [31:0] SEED_ONE_INIT   = 32'h7FED7FED;
    localparam logic [31:0] SEED_TWO_INIT   = 32'hEEEEEEEE;
    localparam logic [10:0] LEN_RESET       = 11'd1024;

    localparam logic [1:0] ST_FOUND     = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [1:0] ST_INSERTED  = 2'd2;
    localparam logic [1:0] ST_FULL      = 2'd3;

    localparam logic OP_LOOKUP = 1'b0;
    localparam logic OP_INSERT = 1'b1;

    typedef logic [31:0] word_t;

    // seed recurrence, only evaluated at elaboration
    function automatic logic [31:0] next_seed(input logic [31:0] s);
        logic [63:0] p;
        begin
            p = {32'd0, s} * 64'd125 + 64'd3;
            return 32'(p % 64'h2AAAAB);
        end
    endfunction

    typedef word_t mix_rom_t [MIX_DEPTH];

    function automatic mix_rom_t build_rom();
        mix_rom_t    rom;
        logic [31:0] s;
        logic [31:0] hi;
        int unsigned at;
        begin
            s = 32'h00100001;
            for (int col = 0; col < 256; col++)
            begin
                for (int row = 0; row < 5; row++)
                begin
                    at = col + row * 256;
                    s  = next_seed(s);
                    hi = {s[15:0], 16'd0};
                    s  = next_seed(s);
                    if (at < MIX_DEPTH)
                        rom[at] = hi | {16'd0, s[15:0]};
                end
            end
            return rom;
        end
    endfunction

    localparam mix_rom_t MIX_ROM = build_rom();

endpackage

// ===== rtl/string_hash_table_probe.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// string_hash_table_probe
// one-way string hash with open addressing insert and lookup
// ----------------------------------------------------------------------------
// usage:
//   a key arrives one byte per transaction on start/operation/key_byte/last,
//   taken when start is high and busy is low. a nonzero byte is upper-cased
//   and folded into three 32-bit hashes, one hash type per cycle through one
//   shared rom/add unit; a zero byte is not folded.
//   on the last byte the table is probed one slot at a time (ram read,
//   then compare), starting at hash0 mod table_length; the modulo is a
//   restoring divider. an insert that finds a free slot writes it, then the
//   result appears on done with status/slot/hashes for one cycle; the
//   receiver cannot stall. busy drops in the cycle done is high. cfg_we
//   writes table_length; the user must write it only while idle, the
//   block itself does not enforce this.
//   after reset busy stays high while a clearing pass zeroes every slot
//   (TABLE_DEPTH slots, 1024 by default); the running hashes clear at
//   once and table_length returns to 1024.
// ----------------------------------------------------------------------------
module string_hash_table_probe #(
    parameter int unsigned TABLE_DEPTH = shtp_pkg::TABLE_DEPTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        operation,
    input  logic [7:0]  key_byte,
    input  logic        last,
    input  logic        cfg_we,
    input  logic [10:0] cfg_wdata,
    output logic        done,
    output logic [1:0]  status,
    output logic [9:0]  slot,
    output logic [31:0] hash_index,
    output logic [31:0] hash_check_a,
    output logic [31:0] hash_check_b
);

    localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int unsigned CW = $clog2(TABLE_DEPTH + 1) + 1;

    typedef enum logic [7:0] {
        S_CLEAR = 8'b00000001,
        S_IDLE  = 8'b00000010,
        S_HASH  = 8'b00000100,
        S_DIV   = 8'b00001000,
        S_READ  = 8'b00010000,
        S_CHECK = 8'b00100000,
        S_WRITE = 8'b01000000,
        S_DONE  = 8'b10000000
    } state_t;

    state_t      state_reg, state_next;
    logic [10:0] len_reg;
    logic [31:0] s1_reg [3];
    logic [31:0] s2_reg [3];
    logic [1:0]  t_reg;
    logic [7:0]  ch_reg;
    logic        op_reg, last_reg;
    logic [31:0] h0_reg, ha_reg, hb_reg;
    logic [31:0] quo_reg;
    logic [31:0] rem_reg;
    logic [5:0]  dcnt_reg;
    logic [AW-1:0] pos_reg;
    logic [CW-1:0] n_reg;
    logic [CW-1:0] probes_reg;
    logic [1:0]  status_reg;
    logic [AW-1:0] slot_reg;
    logic        done_reg;

    // ram word: used flag, check a, check b
    logic [64:0] ram_wdata, ram_rdata;
    logic        ram_we;

    shtp_ram #(.WIDTH(65), .DEPTH(TABLE_DEPTH)) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .addr  (pos_reg),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    assign ram_we    = (state_reg == S_WRITE) || (state_reg == S_CLEAR);
    assign ram_wdata = (state_reg == S_WRITE) ? {1'b1, ha_reg, hb_reg} : '0;

    logic       take;
    logic [7:0] ch_up;
    assign take  = start && !busy;
    assign busy  = (state_reg != S_IDLE);
    assign ch_up = (key_byte inside {[8'h61:8'h7A]}) ? key_byte - 8'h20 : key_byte;

    // shared hash unit
    logic [31:0] mix_w, s1_new, s2_new;
    always_comb
    begin
        mix_w  = shtp_pkg::MIX_ROM[{t_reg, ch_reg}];
        s1_new = mix_w ^ (s1_reg[t_reg] + s2_reg[t_reg]);
        s2_new = {24'd0, ch_reg} + s1_new + s2_reg[t_reg]
                 + {s2_reg[t_reg][26:0], 5'd0} + 32'd3;
    end

    // restoring divide step on h0 by n
    logic [32:0] rem_sh;
    logic [32:0] rem_sub;
    always_comb
    begin
        rem_sh  = {rem_reg, quo_reg[31]};
        rem_sub = rem_sh - {{(33-CW){1'b0}}, n_reg};
    end

    logic [AW-1:0] pos_inc;
    logic          hit;
    logic          probe_used;
    always_comb
    begin
        if ({{(CW-AW){1'b0}}, pos_reg} + CW'(1) >= n_reg)
            pos_inc = '0;
        else
            pos_inc = pos_reg + AW'(1);
        probe_used = ram_rdata[64];
        hit        = (ram_rdata[63:0] == {ha_reg, hb_reg});
    end

    logic [CW-1:0] live_n;
    always_comb
    begin
        if (len_reg == 11'd0)
            live_n = CW'(1);
        else if ({{(32-11){1'b0}}, len_reg} > 32'(TABLE_DEPTH))
            live_n = CW'(TABLE_DEPTH);
        else
            live_n = CW'(len_reg);
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_CLEAR:
                if (pos_reg == AW'(TABLE_DEPTH - 1))
                    state_next = S_IDLE;
            S_IDLE:
                if (take)
                begin
                    if (key_byte != 8'd0)
                        state_next = S_HASH;
                    else if (last)
                        state_next = S_DIV;
                end
            S_HASH:
                if (t_reg == 2'd2)
                    state_next = last_reg ? S_DIV : S_IDLE;
            S_DIV:
                if (dcnt_reg == 6'd32)
                    state_next = S_READ;
            S_READ:  state_next = S_CHECK;
            S_CHECK:
                if (!probe_used)
                    state_next = op_reg ? S_WRITE : S_DONE;
                else if (!op_reg && hit)
                    state_next = S_DONE;
                else if (probes_reg + CW'(1) >= n_reg)
                    state_next = S_DONE;
                else
                    state_next = S_READ;
            S_WRITE: state_next = S_DONE;
            S_DONE:  state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_CLEAR;
            len_reg    <= shtp_pkg::LEN_RESET;
            done_reg   <= 1'b0;
            t_reg      <= 2'd0;
            ch_reg     <= '0;
            op_reg     <= 1'b0;
            last_reg   <= 1'b0;
            h0_reg     <= '0;
            ha_reg     <= '0;
            hb_reg     <= '0;
            quo_reg    <= '0;
            rem_reg    <= '0;
            dcnt_reg   <= '0;
            pos_reg    <= '0;
            n_reg      <= '0;
            probes_reg <= '0;
            status_reg <= '0;
            slot_reg   <= '0;
            for (int i = 0; i < 3; i++)
            begin
                s1_reg[i] <= shtp_pkg::SEED_ONE_INIT;
                s2_reg[i] <= shtp_pkg::SEED_TWO_INIT;
            end
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= 1'b0;
            if (cfg_we)
                len_reg <= cfg_wdata;
            case (state_reg)
                S_CLEAR:
                    pos_reg <= pos_reg + AW'(1);
                S_IDLE:
                    if (take)
                    begin
                        ch_reg   <= ch_up;
                        op_reg   <= operation;
                        last_reg <= last;
                        t_reg    <= 2'd0;
                        if (key_byte == 8'd0 && last)
                        begin
                            h0_reg  <= s1_reg[0];
                            ha_reg  <= s1_reg[1];
                            hb_reg  <= s1_reg[2];
                            quo_reg <= s1_reg[0];
                            rem_reg <= '0;
                            dcnt_reg <= '0;
                            n_reg   <= live_n;
                            for (int i = 0; i < 3; i++)
                            begin
                                s1_reg[i] <= shtp_pkg::SEED_ONE_INIT;
                                s2_reg[i] <= shtp_pkg::SEED_TWO_INIT;
                            end
                        end
                    end
                S_HASH:
                begin
                    t_reg <= t_reg + 2'd1;
                    if (t_reg == 2'd2 && last_reg)
                    begin
                        h0_reg  <= s1_reg[0];
                        ha_reg  <= s1_reg[1];
                        hb_reg  <= s1_new;
                        quo_reg <= s1_reg[0];
                        rem_reg <= '0;
                        dcnt_reg <= '0;
                        n_reg   <= live_n;
                        for (int i = 0; i < 3; i++)
                        begin
                            s1_reg[i] <= shtp_pkg::SEED_ONE_INIT;
                            s2_reg[i] <= shtp_pkg::SEED_TWO_INIT;
                        end
                    end
                    else
                    begin
                        s1_reg[t_reg] <= s1_new;
                        s2_reg[t_reg] <= s2_new;
                    end
                end
                S_DIV:
                    if (dcnt_reg != 6'd32)
                    begin
                        dcnt_reg <= dcnt_reg + 6'd1;
                        quo_reg  <= {quo_reg[30:0], !rem_sub[32]};
                        rem_reg  <= rem_sub[32] ? rem_sh[31:0] : rem_sub[31:0];
                    end
                    else
                    begin
                        pos_reg    <= AW'(rem_reg);
                        probes_reg <= '0;
                    end
                S_CHECK:
                begin
                    if (!probe_used)
                    begin
                        status_reg <= op_reg ? shtp_pkg::ST_INSERTED
                                             : shtp_pkg::ST_NOT_FOUND;
                        slot_reg   <= op_reg ? pos_reg : '0;
                    end
                    else if (!op_reg && hit)
                    begin
                        status_reg <= shtp_pkg::ST_FOUND;
                        slot_reg   <= pos_reg;
                    end
                    else if (probes_reg + CW'(1) >= n_reg)
                    begin
                        status_reg <= op_reg ? shtp_pkg::ST_FULL
                                             : shtp_pkg::ST_NOT_FOUND;
                        slot_reg   <= '0;
                    end
                    else
                    begin
                        pos_reg    <= pos_inc;
                        probes_reg <= probes_reg + CW'(1);
                    end
                end
                S_DONE:
                    done_reg <= 1'b1;
                default: ;
            endcase
        end
    end

    assign done         = done_reg;
    assign status       = status_reg;
    assign slot         = 10'(slot_reg);
    assign hash_index   = h0_reg;
    assign hash_check_a = ha_reg;
    assign hash_check_b = hb_reg;

`ifndef SYNTHESIS
    a_no_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy) else $error("result while busy");
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done) else $error("result held two cycles");
    a_start_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_READ) |-> ({{(CW-AW){1'b0}}, pos_reg} < n_reg))
        else $error("probe beyond table length");
`endif

endmodule

// ===== rtl/shtp_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shtp_ram
// generic single port ram with registered read
// ----------------------------------------------------------------------------
module shtp_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[addr] <= wdata;
        rdata <= mem[addr];
    end

endmodule

// ===== dv/string_hash_table_probe_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// string_hash_table_probe_checker
// watches the key, config and result channels, predicts every result from its
// own hash and table state, and counts mismatches against the block outputs
// ----------------------------------------------------------------------------
module string_hash_table_probe_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic        busy,
    input  logic        operation,
    input  logic [7:0]  key_byte,
    input  logic        last,
    input  logic        cfg_we,
    input  logic [10:0] cfg_wdata,
    input  logic        done,
    input  logic [1:0]  status,
    input  logic [9:0]  slot,
    input  logic [31:0] hash_index,
    input  logic [31:0] hash_check_a,
    input  logic [31:0] hash_check_b,
    output int          errors,
    output int          pending
);

    typedef struct packed {
        logic [1:0]  status;
        logic [9:0]  slot;
        logic [31:0] h0;
        logic [31:0] ha;
        logic [31:0] hb;
    } probe_result_t;

    logic [31:0]   mix_tab [shtp_pkg::MIX_DEPTH];
    logic [31:0]   seed_one [3];
    logic [31:0]   seed_two [3];
    logic          used [shtp_pkg::TABLE_DEPTH_DEF];
    logic [31:0]   stored_a [shtp_pkg::TABLE_DEPTH_DEF];
    logic [31:0]   stored_b [shtp_pkg::TABLE_DEPTH_DEF];
    logic [10:0]   tlen;
    probe_result_t expected_results [$];

    initial
    begin
        logic [63:0] s;
        logic [31:0] hi;
        int          at;
        s = 64'h00100001;
        for (int col = 0; col < 256; col++)
        begin
            for (int row = 0; row < 5; row++)
            begin
                at = col + row * 256;
                s  = (s * 125 + 3) % 64'h2AAAAB;
                hi = {s[15:0], 16'h0000};
                s  = (s * 125 + 3) % 64'h2AAAAB;
                if (at < shtp_pkg::MIX_DEPTH)
                    mix_tab[at] = hi | {16'h0000, s[15:0]};
            end
        end
    end

    function automatic probe_result_t hash_and_probe(input logic op, input logic [7:0] b,
                                                     input logic is_last);
        probe_result_t r;
        logic [31:0]   c, s1, s2;
        int unsigned   n, first, pos;
        logic          full;
        begin
            r = '0;
            if (b != 8'h00)
            begin
                c = {24'h0, b};
                if (b inside {[8'h61:8'h7A]})
                    c = c - 32'h20;
                for (int t = 0; t < 3; t++)
                begin
                    s1 = mix_tab[t * 256 + c] ^ (seed_one[t] + seed_two[t]);
                    s2 = c + s1 + seed_two[t] + (seed_two[t] << 5) + 32'd3;
                    seed_one[t] = s1;
                    seed_two[t] = s2;
                end
            end
            if (is_last)
            begin
                r.h0 = seed_one[0];
                r.ha = seed_one[1];
                r.hb = seed_one[2];
                for (int t = 0; t < 3; t++)
                begin
                    seed_one[t] = shtp_pkg::SEED_ONE_INIT;
                    seed_two[t] = shtp_pkg::SEED_TWO_INIT;
                end
                n = (tlen == 0) ? 1 : tlen;
                if (n > shtp_pkg::TABLE_DEPTH_DEF)
                    n = shtp_pkg::TABLE_DEPTH_DEF;
                first    = r.h0 % n;
                pos      = first;
                r.status = shtp_pkg::ST_NOT_FOUND;
                if (op == shtp_pkg::OP_LOOKUP)
                begin
                    while (used[pos])
                    begin
                        if (stored_a[pos] == r.ha && stored_b[pos] == r.hb)
                        begin
                            r.status = shtp_pkg::ST_FOUND;
                            r.slot   = pos[9:0];
                            break;
                        end
                        pos = (pos + 1) % n;
                        if (pos == first)
                            break;
                    end
                end
                else
                begin
                    full = 1'b0;
                    while (used[pos])
                    begin
                        pos = (pos + 1) % n;
                        if (pos == first)
                        begin
                            full = 1'b1;
                            break;
                        end
                    end
                    if (full)
                        r.status = shtp_pkg::ST_FULL;
                    else
                    begin
                        used[pos]     = 1'b1;
                        stored_a[pos] = r.ha;
                        stored_b[pos] = r.hb;
                        r.status      = shtp_pkg::ST_INSERTED;
                        r.slot        = pos[9:0];
                    end
                end
            end
            return r;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        probe_result_t e, got;
        if (!rst_n)
        begin
            for (int t = 0; t < 3; t++)
            begin
                seed_one[t] = shtp_pkg::SEED_ONE_INIT;
                seed_two[t] = shtp_pkg::SEED_TWO_INIT;
            end
            for (int i = 0; i < shtp_pkg::TABLE_DEPTH_DEF; i++)
                used[i] = 1'b0;
            tlen = shtp_pkg::LEN_RESET;
            expected_results.delete();
            pending = 0;
            errors  = 0;
        end
        else
        begin
            // result first: it belongs to an earlier transaction
            if (done)
            begin
                got = '{status, slot, hash_index, hash_check_a, hash_check_b};
                if (expected_results.size() == 0)
                begin
                    $display("%0t: unexpected result, actual %p", $time, got);
                    errors++;
                end
                else
                begin
                    e = expected_results.pop_front();
                    if (got.status != e.status || got.slot != e.slot)
                    begin
                        $display("%0t: status/slot mismatch, expected %0d/%0d actual %0d/%0d",
                                 $time, e.status, e.slot, got.status, got.slot);
                        errors++;
                    end
                    if (got.h0 != e.h0 || got.ha != e.ha || got.hb != e.hb)
                    begin
                        $display("%0t: hash mismatch, expected %h %h %h actual %h %h %h",
                                 $time, e.h0, e.ha, e.hb, got.h0, got.ha, got.hb);
                        errors++;
                    end
                end
            end
            if (cfg_we)
                tlen = cfg_wdata;
            if (start && !busy)
            begin
                e = hash_and_probe(operation, key_byte, last);
                if (last)
                    expected_results.push_back(e);
            end
            pending = expected_results.size();
        end
    end

endmodule

// ===== dv/string_hash_table_probe_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// string_hash_table_probe_tb
// drives keys byte by byte through directed cases and random phases over
// several table lengths; the checker predicts and compares every result
// ----------------------------------------------------------------------------
module string_hash_table_probe_tb;

    localparam int CYCLE_LIMIT = 20000000;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic        operation;
    logic [7:0]  key_byte;
    logic        last;
    logic        cfg_we;
    logic [10:0] cfg_wdata;
    logic        done;
    logic [1:0]  status;
    logic [9:0]  slot;
    logic [31:0] hash_index;
    logic [31:0] hash_check_a;
    logic [31:0] hash_check_b;
    int          errors;
    int          pending;
    int          cycles;
    int          bytes_sent;
    logic        no_gaps;

    logic [7:0]  key_pool [16][8];
    int          key_len [16];

    string_hash_table_probe i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .operation    (operation),
        .key_byte     (key_byte),
        .last         (last),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .done         (done),
        .status       (status),
        .slot         (slot),
        .hash_index   (hash_index),
        .hash_check_a (hash_check_a),
        .hash_check_b (hash_check_b)
    );

    string_hash_table_probe_checker i_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .operation    (operation),
        .key_byte     (key_byte),
        .last         (last),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .done         (done),
        .status       (status),
        .slot         (slot),
        .hash_index   (hash_index),
        .hash_check_a (hash_check_a),
        .hash_check_b (hash_check_b),
        .errors       (errors),
        .pending      (pending)
    );

    always
    begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic send_byte(input logic op, input logic [7:0] b, input logic is_last);
        if (!no_gaps && $urandom_range(99) < 10)
        begin
            start = 1'b0;
            repeat ($urandom_range(4, 1)) @(negedge clk);
        end
        start     = 1'b1;
        operation = op;
        key_byte  = b;
        last      = is_last;
        while (busy)
            @(negedge clk);
        @(negedge clk);
        start = 1'b0;
        bytes_sent++;
    endtask

    task automatic send_key(input logic op, input int k);
        for (int i = 0; i < key_len[k]; i++)
            send_byte(op, key_pool[k][i], i == key_len[k] - 1);
        if (key_len[k] == 0)
            send_byte(op, 8'h00, 1'b1);
    endtask

    task automatic drain();
        start = 1'b0;
        while (pending != 0)
            @(negedge clk);
        // let a trailing key byte finish hashing
        repeat (16) @(negedge clk);
    endtask

    task automatic write_length(input logic [10:0] v);
        drain();
        cfg_we    = 1'b1;
        cfg_wdata = v;
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    task automatic random_key(input int k);
        key_len[k] = $urandom_range(6);
        for (int i = 0; i < 8; i++)
            key_pool[k][i] = ($urandom_range(3) == 0) ? 8'($urandom_range(255))
                                                      : 8'($urandom_range(8'h7A, 8'h41));
        for (int i = 0; i < key_len[k]; i++)
            if (key_pool[k][i] == 8'h00)
                key_pool[k][i] = 8'h01;
    endtask

    initial
    begin
        logic [10:0] lengths [8];
        int          k;
        lengths    = '{11'd1024, 11'd5, 11'd1, 11'd64, 11'd2047, 11'd0, 11'd300, 11'd1024};
        cycles     = 0;
        bytes_sent = 0;
        no_gaps    = 1'b0;
        rst_n      = 1'b0;
        start      = 1'b0;
        operation  = shtp_pkg::OP_LOOKUP;
        key_byte   = 8'h00;
        last       = 1'b0;
        cfg_we     = 1'b0;
        cfg_wdata  = 11'd0;
        repeat (7) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed: empty key, extremes, case folding, duplicates
        send_byte(shtp_pkg::OP_LOOKUP, 8'h00, 1'b1);
        send_byte(shtp_pkg::OP_INSERT, 8'h00, 1'b1);
        send_byte(shtp_pkg::OP_LOOKUP, 8'h00, 1'b1);
        send_byte(shtp_pkg::OP_INSERT, 8'hFF, 1'b0);
        send_byte(shtp_pkg::OP_INSERT, 8'h00, 1'b0);
        send_byte(shtp_pkg::OP_INSERT, 8'h80, 1'b1);
        send_byte(shtp_pkg::OP_LOOKUP, 8'hFF, 1'b0);
        send_byte(shtp_pkg::OP_LOOKUP, 8'h80, 1'b1);
        send_byte(shtp_pkg::OP_INSERT, 8'h61, 1'b0);
        send_byte(shtp_pkg::OP_INSERT, 8'h7A, 1'b1);
        send_byte(shtp_pkg::OP_LOOKUP, 8'h41, 1'b0);
        send_byte(shtp_pkg::OP_LOOKUP, 8'h5A, 1'b1);
        send_byte(shtp_pkg::OP_INSERT, 8'h41, 1'b0);
        send_byte(shtp_pkg::OP_INSERT, 8'h5A, 1'b1);
        send_byte(shtp_pkg::OP_LOOKUP, 8'h01, 1'b1);
        // slots beyond the length stay but are not probed
        write_length(11'd4);
        send_byte(shtp_pkg::OP_LOOKUP, 8'h00, 1'b1);
        send_byte(shtp_pkg::OP_LOOKUP, 8'h7A, 1'b1);
        // one-slot table fills at once
        write_length(11'd1);
        send_byte(shtp_pkg::OP_INSERT, 8'h42, 1'b1);
        send_byte(shtp_pkg::OP_INSERT, 8'h43, 1'b1);
        send_byte(shtp_pkg::OP_LOOKUP, 8'h43, 1'b1);
        send_byte(shtp_pkg::OP_LOOKUP, 8'h42, 1'b1);

        for (int i = 0; i < 16; i++)
            random_key(i);

        for (int p = 0; p < 8; p++)
        begin
            write_length(lengths[p]);
            while (bytes_sent < 25 + (p + 1) * 191)
            begin
                no_gaps = (bytes_sent > 500 && bytes_sent < 800);
                k = $urandom_range(15);
                case ($urandom_range(19))
                    0:       random_key(k);
                    1:       send_byte(1'($urandom), 8'h00, 1'b0);
                    2:       send_byte(1'($urandom), 8'($urandom_range(255)),
                                       1'($urandom));
                    default: send_key(1'($urandom), k);
                endcase
                if (bytes_sent % 400 == 0)
                    drain();
            end
            // close any key left open by noise
            send_byte(shtp_pkg::OP_LOOKUP, 8'h00, 1'b1);
        end

        drain();
        repeat (2200) @(negedge clk);
        if (errors == 0 && pending == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// ===== string_hash_table_probe.f =====
rtl/shtp_pkg.sv
rtl/shtp_ram.sv
rtl/string_hash_table_probe.sv
dv/string_hash_table_probe_checker.sv
dv/string_hash_table_probe_tb.sv
